/* hdl/elastic_collision_velocity_update_assert.svh */
// ---------------------------------------------------------------------------
// Collision update assertion macros
// Concurrent checks used at the end of the top level; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_VELOCITY_UPDATE_ASSERT_SVH
`define ELASTIC_COLLISION_VELOCITY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ECVU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecvu assertion failed");
// next-cycle implication
`define ECVU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecvu assertion failed");
`else
`define ECVU_ASSERT_IMPL(label, ante, cons)
`define ECVU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/ecvu_pkg.sv */
// ---------------------------------------------------------------------------
// ecvu_pkg
// Widths and pipeline types shared by the collision update modules.
// ---------------------------------------------------------------------------
package ecvu_pkg;

  localparam int LANES = 4;    // first x, first y, second x, second y
  localparam int QW    = 35;   // quotient bits (|change| < 2^34)
  localparam int DENW  = 91;   // |d|^2 * (m1+m2)
  localparam int NW    = 124;  // |dot| * |d_comp| * 2m
  localparam int KW    = 56;   // |d_comp| * m
  localparam int PPW   = 61;   // 33 x 28 partial product
  localparam int CHW   = 37;   // signed velocity change

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic        [23:0] m1;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic        [23:0] m2;
  } item_t;

  // values that ride along the front stages untouched
  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               coinc;
    logic               sx;
    logic               sy;
  } side_t;

  typedef struct packed {
    logic [DENW-1:0]    rem;
    logic [QW-1:0]      nlo;
    logic [QW-1:0]      q;
    logic               neg;
    logic signed [31:0] v;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [DENW-1:0]   den;
    logic              coinc;
  } div_t;

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               coinc;
    logic               sat;
  } result_t;

endpackage

/* hdl/ecvu_front.sv */
// ---------------------------------------------------------------------------
// ecvu_front
// Six stages: differences, products, dot/d^2, magnitudes, partials, numerator.
// ---------------------------------------------------------------------------
module ecvu_front import ecvu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output div_t  out_div
);

  logic [5:0] vld_r;

  // stage 1
  logic signed [32:0] dx_nxt, dy_nxt, dvx_nxt, dvy_nxt;
  logic        [32:0] ndx_w, ndy_w;
  logic        [23:0] m1e_nxt, m2e_nxt;
  logic               mz_w;
  side_t              sd_nxt;
  logic signed [32:0] dx_r, dy_r, dvx_r, dvy_r;
  logic        [31:0] adx_r, ady_r;
  logic        [23:0] m1e_r, m2e_r;
  logic        [24:0] ms1_r;
  side_t              sd1_r;

  always_comb begin
    dx_nxt  = {in_item.p1x[31], in_item.p1x} - {in_item.p2x[31], in_item.p2x};
    dy_nxt  = {in_item.p1y[31], in_item.p1y} - {in_item.p2y[31], in_item.p2y};
    ndx_w   = {in_item.p2x[31], in_item.p2x} - {in_item.p1x[31], in_item.p1x};
    ndy_w   = {in_item.p2y[31], in_item.p2y} - {in_item.p1y[31], in_item.p1y};
    dvx_nxt = {in_item.v2x[31], in_item.v2x} - {in_item.v1x[31], in_item.v1x};
    dvy_nxt = {in_item.v2y[31], in_item.v2y} - {in_item.v1y[31], in_item.v1y};
    mz_w    = (in_item.m1 == 24'd0) && (in_item.m2 == 24'd0);
    m1e_nxt = mz_w ? 24'd1 : in_item.m1;
    m2e_nxt = mz_w ? 24'd1 : in_item.m2;
    sd_nxt.v1x   = in_item.v1x;
    sd_nxt.v1y   = in_item.v1y;
    sd_nxt.v2x   = in_item.v2x;
    sd_nxt.v2y   = in_item.v2y;
    sd_nxt.coinc = (in_item.p1x == in_item.p2x) && (in_item.p1y == in_item.p2y);
    sd_nxt.sx    = dx_nxt[32];
    sd_nxt.sy    = dy_nxt[32];
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dvx_r <= dvx_nxt;
    dvy_r <= dvy_nxt;
    adx_r <= dx_nxt[32] ? ndx_w[31:0] : dx_nxt[31:0];
    ady_r <= dy_nxt[32] ? ndy_w[31:0] : dy_nxt[31:0];
    m1e_r <= m1e_nxt;
    m2e_r <= m2e_nxt;
    ms1_r <= {1'b0, m1e_nxt} + {1'b0, m2e_nxt};
    sd1_r <= sd_nxt;
  end

  // stage 2: all multiplies independent
  logic        [63:0] xx_r, yy_r;
  logic signed [65:0] pdx_r, pdy_r;
  logic [LANES-1:0][KW-1:0] k2_r;
  logic        [24:0] ms2_r;
  side_t              sd2_r;

  always_ff @(posedge clk) begin
    xx_r     <= adx_r * adx_r;
    yy_r     <= ady_r * ady_r;
    pdx_r    <= dx_r * dvx_r;
    pdy_r    <= dy_r * dvy_r;
    k2_r[0]  <= adx_r * m2e_r;
    k2_r[1]  <= ady_r * m2e_r;
    k2_r[2]  <= adx_r * m1e_r;
    k2_r[3]  <= ady_r * m1e_r;
    ms2_r    <= ms1_r;
    sd2_r    <= sd1_r;
  end

  // stage 3: |d|^2 and dot product
  logic        [64:0] d2_r;
  logic signed [66:0] dot_r;
  logic [LANES-1:0][KW-1:0] k3_r;
  logic        [24:0] ms3_r;
  side_t              sd3_r;

  always_ff @(posedge clk) begin
    d2_r  <= {1'b0, xx_r} + {1'b0, yy_r};
    dot_r <= pdx_r + pdy_r;
    k3_r  <= k2_r;
    ms3_r <= ms2_r;
    sd3_r <= sd2_r;
  end

  // stage 4: |dot|, denominator halves
  logic [65:0] adot_r;
  logic        dneg_r;
  logic [57:0] denlo_r;
  logic [56:0] denhi_r;
  logic [LANES-1:0][KW-1:0] k4_r;
  side_t       sd4_r;
  logic signed [66:0] ndot_w;

  assign ndot_w = -dot_r;

  always_ff @(posedge clk) begin
    dneg_r  <= dot_r[66];
    adot_r  <= dot_r[66] ? ndot_w[65:0] : dot_r[65:0];
    denlo_r <= d2_r[32:0] * ms3_r;
    denhi_r <= d2_r[64:33] * ms3_r;
    k4_r    <= k3_r;
    sd4_r   <= sd3_r;
  end

  // stage 5: numerator partial products, denominator sum
  logic [LANES-1:0][3:0][PPW-1:0] pp_nxt;
  logic [LANES-1:0][3:0][PPW-1:0] pp_r;
  logic [DENW-1:0] den5_r;
  logic            dneg5_r;
  side_t           sd5_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pp_nxt[i][0] = adot_r[32:0]  * k4_r[i][27:0];
      pp_nxt[i][1] = adot_r[32:0]  * k4_r[i][55:28];
      pp_nxt[i][2] = adot_r[65:33] * k4_r[i][27:0];
      pp_nxt[i][3] = adot_r[65:33] * k4_r[i][55:28];
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= pp_nxt;
    den5_r  <= DENW'(denlo_r) + (DENW'(denhi_r) << 33);
    dneg5_r <= dneg_r;
    sd5_r   <= sd4_r;
  end

  // stage 6: numerator (x2 folded in), divider seed
  logic [NW-2:0]   nsum_w [LANES];
  logic [NW-1:0]   num_w  [LANES];
  div_t            div_nxt;
  logic [LANES-1:0] lsign_w;
  logic [LANES-1:0][31:0] lv_w;

  always_comb begin
    lsign_w = {~(sd5_r.sy ^ dneg5_r), ~(sd5_r.sx ^ dneg5_r),
               sd5_r.sy ^ dneg5_r, sd5_r.sx ^ dneg5_r};
    lv_w    = {sd5_r.v2y, sd5_r.v2x, sd5_r.v1y, sd5_r.v1x};
    div_nxt.den   = den5_r;
    div_nxt.coinc = sd5_r.coinc;
    for (int i = 0; i < LANES; i++) begin
      nsum_w[i] = (NW-1)'(pp_r[i][0]) + ((NW-1)'(pp_r[i][1]) << 28)
                + ((NW-1)'(pp_r[i][2]) << 33) + ((NW-1)'(pp_r[i][3]) << 61);
      num_w[i]  = {nsum_w[i], 1'b0};
      div_nxt.lane[i].rem = DENW'(num_w[i][NW-1:QW]);
      div_nxt.lane[i].nlo = num_w[i][QW-1:0];
      div_nxt.lane[i].q   = '0;
      div_nxt.lane[i].neg = lsign_w[i];
      div_nxt.lane[i].v   = lv_w[i];
    end
  end

  always_ff @(posedge clk) begin
    out_div <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  assign out_valid = vld_r[5];

endmodule

/* hdl/ecvu_div_step.sv */
// ---------------------------------------------------------------------------
// ecvu_div_step
// One restoring division step for all four lanes, registered.
// ---------------------------------------------------------------------------
module ecvu_div_step import ecvu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  div_t in_div,
  output logic out_valid,
  output div_t out_div
);

  div_t        div_nxt;
  logic [DENW:0] trial_w [LANES];
  logic [DENW:0] diff_w  [LANES];
  logic          ge_w    [LANES];

  always_comb begin
    div_nxt = in_div;
    for (int i = 0; i < LANES; i++) begin
      trial_w[i] = {in_div.lane[i].rem, in_div.lane[i].nlo[QW-1]};
      diff_w[i]  = trial_w[i] - {1'b0, in_div.den};
      ge_w[i]    = trial_w[i] >= {1'b0, in_div.den};
      div_nxt.lane[i].rem = ge_w[i] ? diff_w[i][DENW-1:0] : trial_w[i][DENW-1:0];
      div_nxt.lane[i].nlo = {in_div.lane[i].nlo[QW-2:0], 1'b0};
      div_nxt.lane[i].q   = {in_div.lane[i].q[QW-2:0], ge_w[i]};
    end
  end

  always_ff @(posedge clk) begin
    out_div <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

/* hdl/ecvu_back.sv */
// ---------------------------------------------------------------------------
// ecvu_back
// Rounding and sign of each change, then add and saturate.
// ---------------------------------------------------------------------------
module ecvu_back import ecvu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  div_t    in_div,
  output logic    out_valid,
  output result_t out_res
);

  // stage R1: round half away from zero, apply sign
  logic [QW:0]             qr_w  [LANES];
  logic signed [CHW-1:0]   chg_w [LANES];
  logic [LANES-1:0][CHW-1:0] chg_r;
  logic [LANES-1:0][31:0]  v_r;
  logic                    coinc_r;
  logic                    vld1_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qr_w[i]  = {1'b0, in_div.lane[i].q}
               + (QW+1)'({in_div.lane[i].rem, 1'b0} >= {1'b0, in_div.den});
      chg_w[i] = in_div.lane[i].neg ? -$signed({1'b0, qr_w[i]}) : $signed({1'b0, qr_w[i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      chg_r[i] <= chg_w[i];
      v_r[i]   <= in_div.lane[i].v;
    end
    coinc_r <= in_div.coinc;
  end

  // stage R2: add and clamp
  logic signed [CHW:0]    sum_w [LANES];
  logic [LANES-1:0]       hi_w, lo_w;
  logic [LANES-1:0][31:0] nv_w;
  result_t                res_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum_w[i] = $signed({{(CHW-31){v_r[i][31]}}, v_r[i]}) + $signed({chg_r[i][CHW-1], chg_r[i]});
      hi_w[i]  = sum_w[i] > $signed((CHW+1)'(32'h7FFF_FFFF));
      lo_w[i]  = sum_w[i] < -$signed((CHW+1)'(33'h0_8000_0000));
      if (coinc_r) begin
        nv_w[i] = v_r[i];
      end else if (hi_w[i]) begin
        nv_w[i] = 32'h7FFF_FFFF;
      end else if (lo_w[i]) begin
        nv_w[i] = 32'h8000_0000;
      end else begin
        nv_w[i] = sum_w[i][31:0];
      end
    end
    res_nxt.v1x   = nv_w[0];
    res_nxt.v1y   = nv_w[1];
    res_nxt.v2x   = nv_w[2];
    res_nxt.v2y   = nv_w[3];
    res_nxt.coinc = coinc_r;
    res_nxt.sat   = !coinc_r && ((|hi_w) || (|lo_w));
  end

  always_ff @(posedge clk) begin
    out_res <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1_r    <= in_valid;
      out_valid <= vld1_r;
    end
  end

endmodule

/* hdl/elastic_collision_velocity_update.sv */
// ---------------------------------------------------------------------------
// elastic_collision_velocity_update
// 2D elastic collision of two balls: new velocities along the line of centres.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// input    | start, busy          | in_first_*, in_second_* (pos, vel, mass)
// result   | out_valid (strobe)   | out_*_new_vel_*, out_centres_coincide,
//          |                      | out_result_saturated
//
// One pair enters per cycle; busy is always low. 43 register stages, the
// first loaded at the transfer edge and the last driving the strobe and the
// result: 6 front stages (differences, 33x33 products, sums, magnitudes,
// numerator partials, numerator), 35 restoring divide steps (one quotient
// bit per stage), 2 back stages (round, add/clamp). Synchronous active-low
// reset clears only the valid bits. The receiver takes every strobe, so
// nothing in the pipe ever waits.
// ---------------------------------------------------------------------------
module elastic_collision_velocity_update import ecvu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_pos_x,
  input  logic signed [31:0] in_first_pos_y,
  input  logic signed [31:0] in_first_vel_x,
  input  logic signed [31:0] in_first_vel_y,
  input  logic        [23:0] in_first_mass,
  input  logic signed [31:0] in_second_pos_x,
  input  logic signed [31:0] in_second_pos_y,
  input  logic signed [31:0] in_second_vel_x,
  input  logic signed [31:0] in_second_vel_y,
  input  logic        [23:0] in_second_mass,
  output logic               out_valid,
  output logic signed [31:0] out_first_new_vel_x,
  output logic signed [31:0] out_first_new_vel_y,
  output logic signed [31:0] out_second_new_vel_x,
  output logic signed [31:0] out_second_new_vel_y,
  output logic               out_centres_coincide,
  output logic               out_result_saturated
);

`include "elastic_collision_velocity_update_assert.svh"

  // fully pipelined, never stalls
  assign busy = 1'b0;

  item_t   item_w;
  div_t    dchain [QW+1];
  logic [QW:0] dvalid;
  result_t res_w;

  always_comb begin
    item_w.p1x = in_first_pos_x;
    item_w.p1y = in_first_pos_y;
    item_w.v1x = in_first_vel_x;
    item_w.v1y = in_first_vel_y;
    item_w.m1  = in_first_mass;
    item_w.p2x = in_second_pos_x;
    item_w.p2y = in_second_pos_y;
    item_w.v2x = in_second_vel_x;
    item_w.v2y = in_second_vel_y;
    item_w.m2  = in_second_mass;
  end

  // front: d = p1 - p2, |d|^2*(m1+m2) and |(v2-v1).d|*|d_comp|*2m
  ecvu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (item_w),
    .out_valid (dvalid[0]),
    .out_div   (dchain[0])
  );

  // divider: one quotient bit per stage, four lanes side by side
  for (genvar g = 0; g < QW; g++) begin : g_div
    ecvu_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dvalid[g]),
      .in_div    (dchain[g]),
      .out_valid (dvalid[g+1]),
      .out_div   (dchain[g+1])
    );
  end

  // back: round, sign, add to input velocity, clamp
  ecvu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dvalid[QW]),
    .in_div    (dchain[QW]),
    .out_valid (out_valid),
    .out_res   (res_w)
  );

  assign out_first_new_vel_x  = res_w.v1x;
  assign out_first_new_vel_y  = res_w.v1y;
  assign out_second_new_vel_x = res_w.v2x;
  assign out_second_new_vel_y = res_w.v2y;
  assign out_centres_coincide = res_w.coinc;
  assign out_result_saturated = res_w.sat;

  // a coincident pair passes unchanged, never clamped
  `ECVU_ASSERT_IMPL(a_coinc_no_sat, out_valid && out_centres_coincide, !out_result_saturated)
  // a clamp shows up as an extreme value on some velocity
  `ECVU_ASSERT_IMPL(a_sat_extreme, out_valid && out_result_saturated, (out_first_new_vel_x == 32'sh7FFF_FFFF || out_first_new_vel_x == -32'sh8000_0000 || out_first_new_vel_y == 32'sh7FFF_FFFF || out_first_new_vel_y == -32'sh8000_0000 || out_second_new_vel_x == 32'sh7FFF_FFFF || out_second_new_vel_x == -32'sh8000_0000 || out_second_new_vel_y == 32'sh7FFF_FFFF || out_second_new_vel_y == -32'sh8000_0000))
  // last divide stage always feeds the output through back stages R1 and R2
  `ECVU_ASSERT_IMPL(a_div_to_back, $past(dvalid[QW], 2) && $past(rst_n), out_valid)

endmodule
